@@ sv/blap_pkg.sv @@
`default_nettype none
package blap_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_FRAC_BITS   = 8;
  localparam int ROUND_SHIFT       = 16 - ANGLE_FRAC_BITS;

  // square root pipeline: 80-bit radicand, 40-bit root, one root bit per stage
  localparam int SQRT_STAGES = 40;
  localparam int RAD_W       = 2 * SQRT_STAGES;

  localparam int XY_W = 45;
  localparam int Z_W  = 25;
  localparam logic signed [Z_W-1:0] NINETY_Q16 = 25'sd5898240;

  localparam logic [1:0] REG_LAUNCH_SPEED   = 2'd0;
  localparam logic [1:0] REG_GRAVITY_ACCEL  = 2'd1;
  localparam logic [1:0] REG_FALLBACK_PITCH = 2'd2;

  localparam logic [13:0] LAUNCH_SPEED_RST   = 14'd1000;
  localparam logic [11:0] GRAVITY_ACCEL_RST  = 12'd980;
  localparam logic [15:0] FALLBACK_PITCH_RST = 16'd11520;

  typedef struct packed {
    logic signed [19:0] muzzle_x;
    logic signed [19:0] muzzle_y;
    logic signed [19:0] muzzle_z;
    logic signed [19:0] target_x;
    logic signed [19:0] target_y;
    logic signed [19:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic               no_solution;
  } out_item_t;

  typedef struct packed {
    logic [SQRT_STAGES+1:0] rem;
    logic [SQRT_STAGES-1:0] root;
  } sqrt_st_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117304;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      19: a = 25'sd7;
      20: a = 25'sd4;
      21: a = 25'sd2;
      22: a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one restoring square root digit
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] pair);
    logic [SQRT_STAGES+3:0] r2;
    logic [SQRT_STAGES+3:0] trial;
    sqrt_st_t o;
    r2    = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = (SQRT_STAGES+2)'(r2 - trial);
      o.root = {s.root[SQRT_STAGES-2:0], 1'b1};
    end else begin
      o.rem  = (SQRT_STAGES+2)'(r2);
      o.root = {s.root[SQRT_STAGES-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/ballistic_low_arc_pitch.sv @@
// Low-arc launch pitch solver.
// Input channel (in_valid/in_ready/in_data) takes a muzzle and a target position;
// output channel (out_valid/out_ready/out_data) returns one pitch per beat, signed
// Q8.8 degrees, plus no_solution when the target is out of reach (pitch is then
// fallback_pitch).
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 launch_speed, 1 gravity_accel, 2 fallback_pitch); other indexes are ignored.
// Write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The pipeline
// depth is 64 register stages, the first loaded at the accepting edge: 6 stages
// of differences, products and the discriminant, 40 square root stages (one root
// bit each), one stage for the numerator and g*d, 16 CORDIC stages and the
// output register.
// Reset clears all valid bits and loads the register defaults
// (1000, 980, 45 degrees). When out_ready is low with a result waiting, the
// whole pipeline holds and in_ready drops; nothing is lost or repeated.
`default_nettype none
module ballistic_low_arc_pitch
  import blap_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [13:0] launch_speed;
  logic [11:0] gravity_accel;
  logic [15:0] fallback_pitch;
  logic [27:0] v2;
  logic [23:0] gg;
  logic [55:0] v4;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_speed   <= LAUNCH_SPEED_RST;
      gravity_accel  <= GRAVITY_ACCEL_RST;
      fallback_pitch <= FALLBACK_PITCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAUNCH_SPEED:   launch_speed   <= cfg_data[13:0];
        REG_GRAVITY_ACCEL:  gravity_accel  <= cfg_data[11:0];
        REG_FALLBACK_PITCH: fallback_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived constants, settled well before an item reaches them
  always_ff @(posedge clk) begin
    v2 <= launch_speed * launch_speed;
    gg <= gravity_accel * gravity_accel;
    v4 <= v2 * v2;
  end

  // front stages
  logic               p0_valid, p1_valid, p2_valid, p3_valid, p4_valid, p5_valid;
  logic signed [20:0] p0_dx, p0_dy, p0_h;
  logic [40:0]        p1_dx2, p1_dy2;
  logic [32:0]        p1_gh;
  logic               p1_hneg, p1_hpos;
  logic [41:0]        p2_d2;
  logic [61:0]        p2_t;
  logic               p2_hneg, p2_hpos;
  logic [41:0]        p3_d2;
  logic [62:0]        p3_pos;
  logic [61:0]        p3_add;
  logic [44:0]        p3_nlo, p3_nhi;
  logic [41:0]        p4_d2;
  logic [62:0]        p4_pos;
  logic [67:0]        p4_neg;
  logic [41:0]        p5_d2;
  logic [62:0]        p5_disc;
  logic               p5_fail;

  logic signed [41:0] sq_dx, sq_dy;
  logic [20:0]        habs;
  assign sq_dx = p0_dx * p0_dx;
  assign sq_dy = p0_dy * p0_dy;
  assign habs  = p0_h[20] ? 21'(-p0_h) : 21'(p0_h);

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_dx   <= 21'(in_data.target_x) - 21'(in_data.muzzle_x);
      p0_dy   <= 21'(in_data.target_y) - 21'(in_data.muzzle_y);
      p0_h    <= 21'(in_data.target_z) - 21'(in_data.muzzle_z);

      p1_dx2  <= sq_dx[40:0];
      p1_dy2  <= sq_dy[40:0];
      p1_gh   <= gravity_accel * habs;
      p1_hneg <= p0_h[20];
      p1_hpos <= !p0_h[20] && (p0_h != '0);

      p2_d2   <= 42'(p1_dx2) + 42'(p1_dy2);
      p2_t    <= {61'(p1_gh * v2), 1'b0};
      p2_hneg <= p1_hneg;
      p2_hpos <= p1_hpos;

      p3_d2   <= p2_d2;
      p3_pos  <= 63'(v4) + (p2_hneg ? 63'(p2_t) : 63'd0);
      p3_add  <= p2_hpos ? p2_t : 62'd0;
      p3_nlo  <= gg * p2_d2[20:0];
      p3_nhi  <= gg * p2_d2[41:21];

      p4_d2   <= p3_d2;
      p4_pos  <= p3_pos;
      p4_neg  <= {2'b00, p3_nhi, 21'd0} + 68'(p3_nlo) + 68'(p3_add);

      p5_d2   <= p4_d2;
      p5_fail <= p4_neg > 68'(p4_pos);
      p5_disc <= p4_pos - p4_neg[62:0];
    end
  end

  // square root stages: sqrt(disc << 16) and sqrt(d2 << 16) side by side
  logic     sr_valid [SQRT_STAGES];
  logic     sr_fail  [SQRT_STAGES];
  sqrt_st_t sr_s     [SQRT_STAGES];
  sqrt_st_t sr_d     [SQRT_STAGES];
  logic [RAD_W-1:0] sr_rs [SQRT_STAGES];
  logic [RAD_W-1:0] sr_rd [SQRT_STAGES];

  logic [RAD_W-1:0] rad_s0, rad_d0;
  assign rad_s0 = {1'b0, p5_disc, 16'd0};
  assign rad_d0 = {22'd0, p5_d2, 16'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_fail[0] <= p5_fail;
      sr_s[0]    <= sqrt_step('0, rad_s0[RAD_W-1 -: 2]);
      sr_d[0]    <= sqrt_step('0, rad_d0[RAD_W-1 -: 2]);
      sr_rs[0]   <= {rad_s0[RAD_W-3:0], 2'b00};
      sr_rd[0]   <= {rad_d0[RAD_W-3:0], 2'b00};
      for (int j = 1; j < SQRT_STAGES; j++) begin
        sr_fail[j] <= sr_fail[j-1];
        sr_s[j]    <= sqrt_step(sr_s[j-1], sr_rs[j-1][RAD_W-1 -: 2]);
        sr_d[j]    <= sqrt_step(sr_d[j-1], sr_rd[j-1][RAD_W-1 -: 2]);
        sr_rs[j]   <= {sr_rs[j-1][RAD_W-3:0], 2'b00};
        sr_rd[j]   <= {sr_rd[j-1][RAD_W-3:0], 2'b00};
      end
    end
  end

  // numerator and denominator
  logic               nd_valid, nd_fail;
  logic signed [40:0] nd_num;
  logic [40:0]        nd_den;
  logic [SQRT_STAGES-1:0] root_s, root_d;
  assign root_s = sr_s[SQRT_STAGES-1].root;
  assign root_d = sr_d[SQRT_STAGES-1].root;

  always_ff @(posedge clk) begin
    if (adv) begin
      nd_fail <= sr_fail[SQRT_STAGES-1];
      nd_num  <= $signed({5'd0, v2, 8'd0}) - $signed({1'b0, root_s});
      nd_den  <= gravity_accel * root_d[28:0];
    end
  end

  // vectoring CORDIC, one iteration per stage
  logic                  cr_valid [CORDIC_ITERATIONS];
  logic                  cr_fail  [CORDIC_ITERATIONS];
  logic                  cr_den0  [CORDIC_ITERATIONS];
  logic                  cr_npos  [CORDIC_ITERATIONS];
  logic                  cr_nneg  [CORDIC_ITERATIONS];
  logic signed [XY_W-1:0] cr_x    [CORDIC_ITERATIONS];
  logic signed [XY_W-1:0] cr_y    [CORDIC_ITERATIONS];
  logic signed [Z_W-1:0]  cr_z    [CORDIC_ITERATIONS];

  logic signed [XY_W-1:0] x0, y0;
  assign x0 = $signed({4'd0, nd_den});
  assign y0 = XY_W'(nd_num);

  always_ff @(posedge clk) begin
    if (adv) begin
      cr_fail[0] <= nd_fail;
      cr_den0[0] <= (nd_den == '0);
      cr_npos[0] <= !nd_num[40] && (nd_num != '0);
      cr_nneg[0] <= nd_num[40];
      if (!y0[XY_W-1]) begin
        cr_x[0] <= x0 + y0;
        cr_y[0] <= y0 - x0;
        cr_z[0] <= atan_deg(0);
      end else begin
        cr_x[0] <= x0 - y0;
        cr_y[0] <= y0 + x0;
        cr_z[0] <= -atan_deg(0);
      end
      for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
        cr_fail[i] <= cr_fail[i-1];
        cr_den0[i] <= cr_den0[i-1];
        cr_npos[i] <= cr_npos[i-1];
        cr_nneg[i] <= cr_nneg[i-1];
        if (!cr_y[i-1][XY_W-1]) begin
          cr_x[i] <= cr_x[i-1] + (cr_y[i-1] >>> i);
          cr_y[i] <= cr_y[i-1] - (cr_x[i-1] >>> i);
          cr_z[i] <= cr_z[i-1] + atan_deg(i);
        end else begin
          cr_x[i] <= cr_x[i-1] - (cr_y[i-1] >>> i);
          cr_y[i] <= cr_y[i-1] + (cr_x[i-1] >>> i);
          cr_z[i] <= cr_z[i-1] - atan_deg(i);
        end
      end
    end
  end

  // clamp, round half up, saturate
  localparam int LAST = CORDIC_ITERATIONS - 1;
  localparam logic signed [Z_W:0] HALF =
    (ROUND_SHIFT > 0) ? (Z_W+1)'(1 << (ROUND_SHIFT - 1)) : '0;

  logic signed [Z_W-1:0] z_sel;
  logic signed [Z_W:0]   z_rnd;
  logic signed [15:0]    pitch_next;

  always_comb begin
    if (cr_den0[LAST]) begin
      z_sel = cr_npos[LAST] ? NINETY_Q16 : (cr_nneg[LAST] ? -NINETY_Q16 : '0);
    end else if (cr_z[LAST] > NINETY_Q16) begin
      z_sel = NINETY_Q16;
    end else if (cr_z[LAST] < -NINETY_Q16) begin
      z_sel = -NINETY_Q16;
    end else begin
      z_sel = cr_z[LAST];
    end
    z_rnd = ((Z_W+1)'(z_sel) + HALF) >>> ROUND_SHIFT;
    if (z_rnd > 26'sd32767) begin
      pitch_next = 16'sh7fff;
    end else if (z_rnd < -26'sd32768) begin
      pitch_next = 16'sh8000;
    end else begin
      pitch_next = z_rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.no_solution <= cr_fail[LAST];
      out_data.pitch       <= cr_fail[LAST] ? $signed(fallback_pitch) : pitch_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      p5_valid  <= 1'b0;
      nd_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < SQRT_STAGES; j++) sr_valid[j] <= 1'b0;
      for (int i = 0; i < CORDIC_ITERATIONS; i++) cr_valid[i] <= 1'b0;
    end else if (adv) begin
      p0_valid    <= in_valid;
      p1_valid    <= p0_valid;
      p2_valid    <= p1_valid;
      p3_valid    <= p2_valid;
      p4_valid    <= p3_valid;
      p5_valid    <= p4_valid;
      sr_valid[0] <= p5_valid;
      for (int j = 1; j < SQRT_STAGES; j++) sr_valid[j] <= sr_valid[j-1];
      nd_valid    <= sr_valid[SQRT_STAGES-1];
      cr_valid[0] <= nd_valid;
      for (int i = 1; i < CORDIC_ITERATIONS; i++) cr_valid[i] <= cr_valid[i-1];
      out_valid   <= cr_valid[LAST];
    end
  end

endmodule
`default_nettype wire

@@ sv/blap_checker.sv @@
`default_nettype none
module blap_checker
  import blap_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // nothing waiting at the output means the input side is open
  a_ready_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled output closes the input side
  a_ready_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // reachable pitch stays within +-90 degrees
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.no_solution |->
      (out_data.pitch <= 16'sd23040) && (out_data.pitch >= -16'sd23040))
    else $error("pitch out of range");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ballistic_low_arc_pitch blap_checker u_blap_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ verif/ballistic_low_arc_pitch_tb.sv @@
`timescale 1ns / 100ps
module ballistic_low_arc_pitch_tb;
  import blap_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_TAIL = 80;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // expectation attached to the beat currently offered
  bit        cur_typed = 1'b0;
  out_item_t cur_res = '0;

  logic [13:0] speed_reg;
  logic [11:0] grav_reg;
  logic [15:0] fallback_reg;

  out_item_t pitch_q[$];
  int n_errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_unreach = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  int hold_done = 0;
  bit tx_steady = 1'b0;
  dir_row_t dir_tab[$];

  longint atan_q16[32] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  ballistic_low_arc_pitch u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) root = cand;
    end
    return root;
  endfunction

  function automatic out_item_t solve_pitch(in_item_t it);
    longint dx, dy, h, num, den, x, y, z, xs, ys;
    logic [127:0] d2, v2, g, habs, t, pos, neg, disc, sq, dq;
    out_item_t r;
    dx = longint'(it.target_x) - longint'(it.muzzle_x);
    dy = longint'(it.target_y) - longint'(it.muzzle_y);
    h  = longint'(it.target_z) - longint'(it.muzzle_z);
    d2 = 128'(dx * dx + dy * dy);
    v2 = 128'(speed_reg) * 128'(speed_reg);
    g  = 128'(grav_reg);
    habs = 128'((h < 0) ? -h : h);
    t = 2 * g * habs * v2;
    pos = v2 * v2 + ((h < 0) ? t : 128'd0);
    neg = g * g * d2 + ((h > 0) ? t : 128'd0);
    if (neg > pos) begin
      r.pitch = fallback_reg;
      r.no_solution = 1'b1;
      return r;
    end
    disc = pos - neg;
    sq = 128'(int_sqrt(disc << 16));
    dq = 128'(int_sqrt(d2 << 16));
    num = longint'(v2 << 8) - longint'(sq);
    den = longint'(g * dq);
    if (den == 0) begin
      z = (num > 0) ? 90 * 65536 : ((num < 0) ? -90 * 65536 : 0);
    end else begin
      x = den;
      y = num;
      z = 0;
      for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_q16[i];
        end
      end
      if (z > 90 * 65536) z = 90 * 65536;
      if (z < -90 * 65536) z = -90 * 65536;
    end
    if (ROUND_SHIFT > 0) z = (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    r.pitch = 16'(z);
    r.no_solution = 1'b0;
    return r;
  endfunction

  function automatic void add_row(int mx, int my, int mz, int tx, int ty, int tz,
                                  bit typed, int pitch, bit unreach);
    dir_row_t row;
    row.it = '{20'(mx), 20'(my), 20'(mz), 20'(tx), 20'(ty), 20'(tz)};
    row.typed = typed;
    row.res.pitch = 16'(pitch);
    row.res.no_solution = unreach;
    dir_tab.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int s;
    it.muzzle_x = 20'($urandom);
    it.muzzle_y = 20'($urandom);
    it.muzzle_z = 20'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      it.target_x = 20'($urandom);
      it.target_y = 20'($urandom);
      it.target_z = 20'($urandom);
    end else begin
      // mostly nearby targets so the solvable region gets hit
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 12);
      it.target_x = it.muzzle_x + 20'($signed($urandom_range(0, 1 << s)) *
                     ($urandom_range(0, 1) ? 1 : -1));
      it.target_y = it.muzzle_y + 20'($signed($urandom_range(0, 1 << s)) *
                     ($urandom_range(0, 1) ? 1 : -1));
      it.target_z = it.muzzle_z + 20'($signed($urandom_range(0, 1 << s)) *
                     ($urandom_range(0, 1) ? 1 : -1));
    end
    return it;
  endfunction

  task automatic send_beat(in_item_t it, bit typed, out_item_t res);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    cur_typed <= typed;
    cur_res   <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pitch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_LAUNCH_SPEED:   speed_reg = val[13:0];
      REG_GRAVITY_ACCEL:  grav_reg = val[11:0];
      REG_FALLBACK_PITCH: fallback_reg = val;
      default: ;
    endcase
  endtask

  // beat bookkeeping and result checks
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pitch_q.push_back(cur_typed ? cur_res : solve_pitch(in_data));
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (out_data.no_solution) n_unreach++;
        if (pitch_q.size() == 0) begin
          $error("result beat with nothing expected: pitch %0d", out_data.pitch);
          n_errors++;
        end else begin
          if (out_data.pitch !== pitch_q[0].pitch) begin
            $error("pitch: expected %0d, actual %0d", pitch_q[0].pitch, out_data.pitch);
            n_errors++;
          end
          if (out_data.no_solution !== pitch_q[0].no_solution) begin
            $error("no_solution: expected %0b, actual %0b",
                   pitch_q[0].no_solution, out_data.no_solution);
            n_errors++;
          end
          void'(pitch_q.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("ballistic_low_arc_pitch regression: fail");
        $finish;
      end
    end
  end

  // receiver side: random backpressure plus requested long holds
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] spd [N_PHASES];
    logic [15:0] grv [N_PHASES];
    logic [15:0] fbk [N_PHASES];
    out_item_t none;
    none = '0;
    speed_reg = LAUNCH_SPEED_RST;
    grav_reg = GRAVITY_ACCEL_RST;
    fallback_reg = FALLBACK_PITCH_RST;

    // typed rows assume the reset register values
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(-524288, -524288, 0, 524287, 524287, 0, 1, 11520, 1);
    add_row(524287, 524287, 524287, -524288, -524288, -524288, 1, 11520, 1);
    add_row(5, 5, 0, 5, 5, 10, 1, 23040, 0);
    add_row(0, 0, 524287, 0, 0, -524288, 1, -23040, 0);
    add_row(-524288, 0, 0, -524288, 0, 524287, 1, 11520, 1);
    add_row(0, 0, 0, 100, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 500, 200, 0, 0, 0);
    add_row(0, 0, 0, 700, 700, 0, 0, 0, 0);
    add_row(0, 0, 0, 1, 1, 0, 0, 0, 0);
    add_row(100, 100, 100, 100, 1120, 100, 0, 0, 0);
    add_row(0, 0, 0, 1020, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 300, -400, -1000, 0, 0, 0);
    add_row(-1, -1, -1, 0, 0, 0, 0, 0, 0);
    add_row(524287, -524288, 0, 524000, -524000, 50, 0, 0, 0);
    add_row(-200, 300, 5000, 0, 0, -5000, 0, 0, 0);

    spd = '{16'd1000, 16'd16383, 16'd0, 16'd16383, 16'd200, 16'd1, 16'hFFFF, 16'd0};
    grv = '{16'd980, 16'd4095, 16'd1, 16'd1, 16'd0, 16'd4095, 16'hFFFF, 16'd0};
    fbk = '{16'd11520, 16'h A600, 16'd23040, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'd0};
    spd[7] = 16'($urandom_range(0, 16383));
    grv[7] = 16'($urandom_range(1, 4095));
    fbk[7] = 16'($urandom_range(0, 46080) - 23040);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) send_beat(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].res);
    // sender waits for every result before moving on
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_LAUNCH_SPEED, spd[p]);
      write_reg(REG_GRAVITY_ACCEL, grv[p]);
      write_reg(REG_FALLBACK_PITCH, fbk[p]);
      if (p == 3) write_reg(REG_UNUSED, 16'($urandom));
      cfg_we <= 1'b0;
      tx_steady = (p == 1 || p == 5);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && (p == 1 || p == 4)) hold_req++;
        send_beat(rand_item(), 1'b0, none);
      end
      drain();
    end

    $display("accepted %0d input beats, checked %0d result beats (%0d unreachable)",
             n_in, n_out, n_unreach);
    $display("covered %0d register settings incl. range extremes and an ignored index",
             N_PHASES);
    if (n_errors == 0 && pitch_q.size() == 0) begin
      $display("ballistic_low_arc_pitch regression: pass");
    end else begin
      if (pitch_q.size() != 0) $error("%0d expected results never arrived", pitch_q.size());
      $display("ballistic_low_arc_pitch regression: fail");
    end
    $finish;
  end

endmodule

@@ ballistic_low_arc_pitch.f @@
sv/blap_pkg.sv
sv/ballistic_low_arc_pitch.sv
sv/blap_checker.sv
verif/ballistic_low_arc_pitch_tb.sv
